[hw/rtl/dq_pkg.sv]
// ---------------------------------------------------------------------------
// dq_pkg - shared codes for the double-ended queue
// Action codes for the input item and status codes for the result item.
// ---------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // Action requested by one input transfer
  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  // Status reported with each result transfer
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 5;

endpackage : dq_pkg

`default_nettype wire

[hw/rtl/double_ended_queue_top.sv]
// ---------------------------------------------------------------------------
// double_ended_queue_top - fixed-capacity deque of signed 32-bit words
// Ring buffer in a one-port-write / one-port-read synchronous memory,
// addressed by a head index and a held count.
// ---------------------------------------------------------------------------
// One action is taken per clock: busy stays low, so start may be held high
// on every cycle. The result of an action shows on the out_ ports in the cycle
// after its transfer, for exactly one cycle, flagged by out_valid; the
// receiver cannot stall it. The result is delayed by the registered read
// port of the entry memory, which a pop reads in the transfer cycle. Head and
// count registers update at the transfer edge, and a write to the memory lands
// at that same edge, so an entry pushed in one cycle can be popped in the
// next. Pushing onto a full deque reports overflow, popping an empty one
// reports underflow; neither changes the contents. out_pop_value is zero
// unless a pop succeeded. out_entry_count is the held count after the action,
// kept to its low five bits.
`default_nettype none

module double_ended_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // command channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_action,
  input  wire logic signed [31:0]          in_push_value,
  // result channel
  output logic                             out_valid,
  output logic signed [31:0]               out_pop_value,
  output logic [1:0]                       out_status,
  output logic [4:0]                       out_entry_count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned XW = CW + dq_pkg::COUNT_W;

  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // Entry memory: written and read in clocked blocks
  logic [dq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [dq_pkg::WORD_W-1:0] mem_q_r;

  // Ring control
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Result registers
  logic                    valid_r;
  dq_pkg::status_t         status_r, status_nxt;
  logic                    pop_ok_r, pop_ok_nxt;

  logic                    accept;
  logic                    full, empty;
  logic [SW-1:0]           sum_back, sum_last;
  logic [AW-1:0]           slot_back, slot_last, head_dec, head_inc;
  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic [XW-1:0]           count_ext;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign full   = (count_r == DEPTH_C);
  assign empty  = (count_r == '0);

  // Ring slot arithmetic; sums stay below twice DEPTH
  always_comb begin
    sum_back  = SW'(head_r) + SW'(count_r);
    sum_last  = sum_back - SW'(1);
    slot_back = (sum_back >= DEPTH_S) ? AW'(sum_back - DEPTH_S) : AW'(sum_back);
    slot_last = (sum_last >= DEPTH_S) ? AW'(sum_last - DEPTH_S) : AW'(sum_last);
    head_dec  = (head_r == '0) ? LAST_A : head_r - AW'(1);
    head_inc  = (head_r == LAST_A) ? '0 : head_r + AW'(1);
  end

  // Action decode: next pointers, memory access, result status
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = dq_pkg::ST_OK;
    pop_ok_nxt = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = slot_back;
    raddr      = head_r;
    if (accept) begin
      case (dq_pkg::action_t'(in_action))
        dq_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            status_nxt = dq_pkg::ST_OVERFLOW;
          end else begin
            we        = 1'b1;
            waddr     = slot_back;
            count_nxt = count_r + CW'(1);
          end
        end
        dq_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            status_nxt = dq_pkg::ST_OVERFLOW;
          end else begin
            we        = 1'b1;
            waddr     = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        dq_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            status_nxt = dq_pkg::ST_UNDERFLOW;
          end else begin
            re         = 1'b1;
            raddr      = head_r;
            pop_ok_nxt = 1'b1;
            head_nxt   = head_inc;
            count_nxt  = count_r - CW'(1);
          end
        end
        dq_pkg::ACT_POP_BACK: begin
          if (empty) begin
            status_nxt = dq_pkg::ST_UNDERFLOW;
          end else begin
            re         = 1'b1;
            raddr      = slot_last;
            pop_ok_nxt = 1'b1;
            count_nxt  = count_r - CW'(1);
          end
        end
        default: begin
          status_nxt = dq_pkg::ST_OK;
        end
      endcase
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= in_push_value;
    end
  end

  // Memory read port, registered data
  always_ff @(posedge clk) begin
    if (re) begin
      mem_q_r <= mem[raddr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      valid_r  <= 1'b0;
      status_r <= dq_pkg::ST_OK;
      pop_ok_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      valid_r  <= accept;
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  // Result ports; count reported in its low five bits
  assign count_ext       = XW'(count_r);
  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_pop_value   = pop_ok_r ? mem_q_r : '0;
  assign out_entry_count = count_ext[dq_pkg::COUNT_W-1:0];

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("held count above capacity");

  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result transfer missing after command transfer");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status_r == dq_pkg::ST_OVERFLOW) |-> full)
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status_r == dq_pkg::ST_UNDERFLOW) |-> empty)
    else $error("underflow reported while not empty");

  a_pop_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok_r |-> (status_r == dq_pkg::ST_OK))
    else $error("pop data flagged on a failed action");

endmodule : double_ended_queue_top

`default_nettype wire
